// ===== sv/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

  // Sizes
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OFF_W  = ADDR_W + 1;
  localparam int CNT_W  = 11;
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef logic [ADDR_W-1:0] ptr_t;
  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  localparam cnt_t CAP_RESET = cnt_t'(1024);
  localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);
  localparam off_t DEPTH_OFF = off_t'(DEPTH);
  localparam ptr_t PTR_LAST  = ptr_t'(DEPTH - 1);

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_STATUS     = 3'd4;

  // Configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;

  // Request from control to the entry memory
  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    word_t wdata;
    logic  re;
    ptr_t  raddr_front;
    ptr_t  raddr_rear;
  } mem_req_t;

  // Circular index: (head + off) mod DEPTH, off at most DEPTH
  function automatic ptr_t slot(input ptr_t head, input off_t off);
    off_t sum;
    sum = {1'b0, head} + off;
    if (sum >= DEPTH_OFF) begin
      sum = sum - DEPTH_OFF;
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== sv/bdq_if.sv =====
`timescale 1ns / 1ps

// Operation request channel
interface bdq_in_if;
  import bdq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

// Result channel
interface bdq_out_if;
  import bdq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;
  logic                     is_empty;
  logic                     is_full;
  logic [CNT_W-1:0]         fill_count;

  modport source (output valid, output ok, output front_value, output rear_value,
                  output is_empty, output is_full, output fill_count, input ready);
  modport sink   (input valid, input ok, input front_value, input rear_value,
                  input is_empty, input is_full, input fill_count, output ready);
endinterface

// ===== sv/bdq_cfg_regs.sv =====
`timescale 1ns / 1ps

module bdq_cfg_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [bdq_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [bdq_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [bdq_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output bdq_pkg::cnt_t          cap_eff
);
  import bdq_pkg::*;

  cnt_t capacity_r;
  cnt_t capacity_nxt;
  logic wr_capacity;
  logic reg_idx;

  assign reg_idx     = cfg_paddr[2];
  assign cfg_pready  = 1'b1;
  assign wr_capacity = cfg_psel && cfg_penable && cfg_pwrite && (reg_idx == REG_CAPACITY);

  // Capacity register
  always_comb begin
    capacity_nxt = capacity_r;
    if (wr_capacity) begin
      capacity_nxt = cfg_pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  // Read-back
  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == REG_CAPACITY) begin
      cfg_prdata = CFG_DW'(capacity_r);
    end
  end

  // Saturate to the memory depth
  assign cap_eff = (capacity_r > DEPTH_CNT) ? DEPTH_CNT : capacity_r;

endmodule

// ===== sv/bdq_store.sv =====
`timescale 1ns / 1ps

// Entry memory: one write port, two registered read ports
module bdq_store (
  input  logic              clk,
  input  bdq_pkg::mem_req_t req,
  output bdq_pkg::word_t    rd_front,
  output bdq_pkg::word_t    rd_rear
);
  import bdq_pkg::*;

  word_t mem [DEPTH];
  word_t rd_front_r;
  word_t rd_rear_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_front_r <= mem[req.raddr_front];
      rd_rear_r  <= mem[req.raddr_rear];
    end
  end

  assign rd_front = rd_front_r;
  assign rd_rear  = rd_rear_r;

endmodule

// ===== sv/bdq_ctrl.sv =====
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  bdq_pkg::cnt_t     cap_eff,
  bdq_in_if.sink            in_ch,
  bdq_out_if.source         out_ch,
  output bdq_pkg::mem_req_t mem_req,
  input  bdq_pkg::word_t    rd_front,
  input  bdq_pkg::word_t    rd_rear
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DONE} state_t;

  state_t state_r, state_nxt;
  ptr_t   head_r, head_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic   ok_r, ok_nxt;

  logic   out_valid_r, out_valid_nxt;
  logic   out_ok_r, out_ok_nxt;
  word_t  out_front_r, out_front_nxt;
  word_t  out_rear_r, out_rear_nxt;
  logic   out_empty_r, out_empty_nxt;
  logic   out_full_r, out_full_nxt;
  cnt_t   out_cnt_r, out_cnt_nxt;

  logic   accept;
  logic   can_push;
  logic   can_pop;
  logic   out_free;
  logic   cnt_zero;
  ptr_t   head_dec;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign can_push    = cnt_r < cap_eff;
  assign can_pop     = cnt_r != '0;
  assign cnt_zero    = cnt_r == '0;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign head_dec    = (head_r == '0) ? PTR_LAST : head_r - ptr_t'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_front_nxt = out_front_r;
    out_rear_nxt  = out_rear_r;
    out_empty_nxt = out_empty_r;
    out_full_nxt  = out_full_r;
    out_cnt_nxt   = out_cnt_r;

    mem_req             = '0;
    mem_req.wdata       = in_ch.push_value;
    mem_req.raddr_front = head_r;
    mem_req.raddr_rear  = slot(head_r, off_t'(cnt_r - cnt_t'(1)));

    // Result taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Apply the operation to pointers and write the pushed word
      ST_IDLE: begin
        if (accept) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_READ;
          unique case (in_ch.func)
            FN_PUSH_FRONT: begin
              if (can_push) begin
                head_nxt      = head_dec;
                mem_req.we    = 1'b1;
                mem_req.waddr = head_dec;
                cnt_nxt       = cnt_r + cnt_t'(1);
                ok_nxt        = 1'b1;
              end
            end
            FN_PUSH_BACK: begin
              if (can_push) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = slot(head_r, off_t'(cnt_r));
                cnt_nxt       = cnt_r + cnt_t'(1);
                ok_nxt        = 1'b1;
              end
            end
            FN_POP_FRONT: begin
              if (can_pop) begin
                head_nxt = slot(head_r, off_t'(1));
                cnt_nxt  = cnt_r - cnt_t'(1);
                ok_nxt   = 1'b1;
              end
            end
            FN_POP_BACK: begin
              if (can_pop) begin
                cnt_nxt = cnt_r - cnt_t'(1);
                ok_nxt  = 1'b1;
              end
            end
            FN_STATUS: ok_nxt = 1'b1;
            default:   ok_nxt = 1'b0;
          endcase
        end
      end
      // Fetch the new front and rear entries
      ST_READ: begin
        mem_req.re = 1'b1;
        state_nxt  = ST_DONE;
      end
      // Load the result register once it is free
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_front_nxt = cnt_zero ? '1 : rd_front;
          out_rear_nxt  = cnt_zero ? '1 : rd_rear;
          out_empty_nxt = cnt_zero;
          out_full_nxt  = cnt_r >= cap_eff;
          out_cnt_nxt   = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ok_r        <= ok_nxt;
    out_ok_r    <= out_ok_nxt;
    out_front_r <= out_front_nxt;
    out_rear_r  <= out_rear_nxt;
    out_empty_r <= out_empty_nxt;
    out_full_r  <= out_full_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.front_value = out_front_r;
  assign out_ch.rear_value  = out_rear_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.is_full     = out_full_r;
  assign out_ch.fill_count  = out_cnt_r;

endmodule

// ===== sv/bounded_double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// An input transfer is followed by the registered memory read and then the result load.
// One item is in progress at a time, set by the write-then-read sequence on the entry memory;
//   a pending result waits in the output register while the next item proceeds.
// Reset (rst_n low, synchronous): deque empty, head at 0, capacity 1024, output idle.
//   The entry memory is not cleared; an empty deque returns all ones in place of read data.
module bounded_double_ended_queue_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  bdq_in_if.sink                     in_ch,
  bdq_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bdq_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [bdq_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [bdq_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import bdq_pkg::*;

  cnt_t     cap_eff;
  mem_req_t mem_req;
  word_t    rd_front;
  word_t    rd_rear;

  bdq_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cap_eff     (cap_eff)
  );

  bdq_store u_store (
    .clk      (clk),
    .req      (mem_req),
    .rd_front (rd_front),
    .rd_rear  (rd_rear)
  );

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cap_eff  (cap_eff),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .mem_req  (mem_req),
    .rd_front (rd_front),
    .rd_rear  (rd_rear)
  );

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.fill_count <= DEPTH_CNT))
    else $error("fill count above depth");

  a_empty_vals: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.is_empty) |->
      (out_ch.fill_count == '0 && out_ch.front_value == -32'sd1
       && out_ch.rear_value == -32'sd1))
    else $error("empty result inconsistent");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("memory write overlaps read");

endmodule
